@@ sv/mipd_pkg.sv @@
// ----------------------------------------------------------------------------
// mipd_pkg
// shared widths, register indexes and controller command type
// ----------------------------------------------------------------------------
package mipd_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned BoxW   = 31;
  localparam int unsigned DispW  = 34;
  localparam int unsigned DistW  = 35;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned SumW   = 70;
  localparam int unsigned RemW   = 38;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgAddrW-1:0] RegPbcEnable = 2'd0;
  localparam logic [CfgAddrW-1:0] RegBoxX      = 2'd1;
  localparam logic [CfgAddrW-1:0] RegBoxY      = 2'd2;
  localparam logic [CfgAddrW-1:0] RegBoxZ      = 2'd3;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [1:0] PartLoLo = 2'd0;
  localparam logic [1:0] PartHiLo = 2'd1;
  localparam logic [1:0] PartHiHi = 2'd2;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       wrap;
    logic       mul;
    logic [1:0] axis;
    logic [1:0] part;
    logic       sq_step;
    logic       zero;
  } cmd_t;

endpackage

@@ sv/mipd_datapath.sv @@
// ----------------------------------------------------------------------------
// mipd_datapath
// atom store, displacement wrap, squared sum and bit-serial square root
// ----------------------------------------------------------------------------
module mipd_datapath #(
  parameter int unsigned MAX_ATOMS = 64,
  parameter int unsigned AW = $clog2(MAX_ATOMS)
) (
  input  logic                           clk_i,
  input  mipd_pkg::cmd_t                 cmd_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [AW-1:0]                  rd_addr_i,
  input  logic [mipd_pkg::InDataW-1:0]   pos_i,
  input  logic                           pbc_enable_i,
  input  logic [mipd_pkg::BoxW-1:0]      box_x_i,
  input  logic [mipd_pkg::BoxW-1:0]      box_y_i,
  input  logic [mipd_pkg::BoxW-1:0]      box_z_i,
  output logic [mipd_pkg::DispW-1:0]     disp_x_o,
  output logic [mipd_pkg::DispW-1:0]     disp_y_o,
  output logic [mipd_pkg::DispW-1:0]     disp_z_o,
  output logic [mipd_pkg::DistW-1:0]     dist_o
);
  import mipd_pkg::*;

  logic [InDataW-1:0] mem [MAX_ATOMS];
  logic [InDataW-1:0] rdata_q;
  logic [InDataW-1:0] pos_q;
  logic [DispW-1:0]   disp_q [3];
  logic [DispW-1:0]   disp_d [3];
  logic [SumW-1:0]    sum_q, sum_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [DistW-1:0]   root_q, root_d;
  logic [BoxW-1:0]    box [3];
  logic [DispW-1:0]   dsel;
  logic [PosW-1:0]    amag;
  logic [15:0]        op_a, op_b;
  logic [31:0]        prod;
  logic [SumW-1:0]    term;
  logic [RemW-1:0]    rem_sh, trial;

  assign box[0] = box_x_i;
  assign box[1] = box_y_i;
  assign box[2] = box_z_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= pos_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // per-axis difference and one minimum-image correction
  always_comb begin
    logic signed [DispW-1:0] d;
    logic signed [DispW:0]   d2;
    logic signed [DispW:0]   l;
    for (int k = 0; k < 3; k++) begin
      d  = DispW'($signed(pos_q[k*PosW +: PosW])) -
           DispW'($signed(rdata_q[k*PosW +: PosW]));
      d2 = {d, 1'b0};
      l  = (DispW+1)'(box[k]);
      if (pbc_enable_i && (d2 > l)) begin
        disp_d[k] = DispW'(d - DispW'(box[k]));
      end else if (pbc_enable_i && (d2 < -l)) begin
        disp_d[k] = DispW'(d + DispW'(box[k]));
      end else begin
        disp_d[k] = d;
      end
    end
  end

  always_comb begin
    case (cmd_i.axis)
      AxisX:   dsel = disp_q[0];
      AxisY:   dsel = disp_q[1];
      AxisZ:   dsel = disp_q[2];
      default: dsel = '0;
    endcase
    amag = dsel[DispW-1] ? PosW'(-dsel) : PosW'(dsel);
    case (cmd_i.part)
      PartLoLo: begin op_a = amag[15:0];  op_b = amag[15:0]; end
      PartHiLo: begin op_a = amag[31:16]; op_b = amag[15:0]; end
      PartHiHi: begin op_a = amag[31:16]; op_b = amag[31:16]; end
      default:  begin op_a = '0;          op_b = '0;         end
    endcase
    prod = 32'(op_a) * 32'(op_b);
    case (cmd_i.part)
      PartLoLo: term = SumW'(prod);
      PartHiLo: term = SumW'(prod) << 17;
      PartHiHi: term = SumW'(prod) << 32;
      default:  term = '0;
    endcase
  end

  // restoring square root, two radicand bits per step
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], sum_q[SumW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    sum_d  = sum_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.wrap) begin
      sum_d  = '0;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.mul) begin
      sum_d = sum_q + term;
    end else if (cmd_i.sq_step) begin
      sum_d = sum_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DistW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      pos_q <= pos_i;
    end
    if (cmd_i.wrap) begin
      for (int k = 0; k < 3; k++) disp_q[k] <= disp_d[k];
    end
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign disp_x_o = cmd_i.zero ? '0 : disp_q[0];
  assign disp_y_o = cmd_i.zero ? '0 : disp_q[1];
  assign disp_z_o = cmd_i.zero ? '0 : disp_q[2];
  assign dist_o   = cmd_i.zero ? '0 : root_q;

endmodule

@@ sv/mipd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mipd_ctrl
// sequencer over stored atoms, multiply and square-root steps
// ----------------------------------------------------------------------------
module mipd_ctrl #(
  parameter int unsigned MAX_ATOMS = 64,
  parameter int unsigned AW = $clog2(MAX_ATOMS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     start_new_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [mipd_pkg::IdxW-1:0] index_i_o,
  output logic [mipd_pkg::IdxW-1:0] index_j_o,
  output logic                     overflow_o,
  output logic                     last_o,
  output mipd_pkg::cmd_t           cmd_o,
  output logic [AW-1:0]            wr_addr_o,
  output logic [AW-1:0]            rd_addr_o
);
  import mipd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_WRAP = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQRT = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   i_q, i_d, j_q, j_d;
  logic [1:0]      axis_q, axis_d, part_q, part_d;
  logic [5:0]      step_q, step_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   n;
  logic            last;

  assign n    = start_new_i ? '0 : count_q;
  assign last = ((AW+1)'(j_q) + (AW+1)'(1)) == (AW+1)'(i_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    axis_d  = axis_q;
    part_d  = part_q;
    step_d  = step_q;
    ovf_d   = ovf_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;
    cmd_o.part = part_q;
    cmd_o.zero = ovf_q;
    wr_addr_o  = n[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (n >= CW'(MAX_ATOMS)) begin
            ovf_d   = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.wr = 1'b1;
            ovf_d    = 1'b0;
            i_d      = n[AW-1:0];
            j_d      = '0;
            count_d  = n + CW'(1);
            if (n != '0) state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        axis_d     = AxisX;
        part_d     = PartLoLo;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (part_q == PartHiHi) begin
          part_d = PartLoLo;
          if (axis_q == AxisZ) begin
            step_d  = '0;
            state_d = S_SQRT;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          part_d = part_q + 2'd1;
        end
      end
      S_SQRT: begin
        cmd_o.sq_step = 1'b1;
        step_d = step_q + 6'd1;
        if (step_q == 6'(DistW - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (ovf_q || last) begin
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + AW'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      axis_q  <= '0;
      part_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      axis_q  <= axis_d;
      part_q  <= part_d;
      step_q  <= step_d;
    end
  end

  assign rd_addr_o   = j_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign index_i_o   = ovf_q ? '0 : IdxW'(i_q);
  assign index_j_o   = ovf_q ? '0 : IdxW'(j_q);
  assign overflow_o  = ovf_q;
  assign last_o      = ovf_q | last;

endmodule

@@ sv/min_image_pair_distances.sv @@
// ----------------------------------------------------------------------------
// min_image_pair_distances
// pairs each new atom with all stored atoms, emitting wrapped displacement
// and distance
// ----------------------------------------------------------------------------
// An atom is taken only while the block is idle. Atom i stores its position
// and then produces i results, one per earlier atom, in index order; each
// result passes through a store read, the wrap, the squared sum on one 16x16
// multiplier, 35 square-root steps and an output state that waits for the
// result side. The first atom of a structure gives no result; an atom that
// finds the store full gives one overflow result and is dropped.
module min_image_pair_distances #(
  parameter int unsigned MAX_ATOMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pos_x, pos_y, pos_z
  input  logic [mipd_pkg::InDataW-1:0]      s_axis_tdata,
  // start_new
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // index_i, index_j, disp_x, disp_y, disp_z, pair_distance, zero fill
  output logic [mipd_pkg::OutDataW-1:0]     m_axis_tdata,
  // overflow
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [mipd_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [mipd_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import mipd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ATOMS);

  logic            pbc_q;
  logic [BoxW-1:0] box_x_q, box_y_q, box_z_q;
  cmd_t            cmd;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [IdxW-1:0] index_i, index_j;
  logic [DispW-1:0] disp_x, disp_y, disp_z;
  logic [DistW-1:0] pair_dist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbc_q   <= 1'b0;
      box_x_q <= '0;
      box_y_q <= '0;
      box_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegPbcEnable: pbc_q   <= cfg_wdata_i[0];
        RegBoxX:      box_x_q <= cfg_wdata_i;
        RegBoxY:      box_y_q <= cfg_wdata_i;
        RegBoxZ:      box_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mipd_ctrl #(
    .MAX_ATOMS(MAX_ATOMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .start_new_i(s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .index_i_o  (index_i),
    .index_j_o  (index_j),
    .overflow_o (m_axis_tuser),
    .last_o     (m_axis_tlast),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  mipd_datapath #(
    .MAX_ATOMS(MAX_ATOMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .pos_i       (s_axis_tdata),
    .pbc_enable_i(pbc_q),
    .box_x_i     (box_x_q),
    .box_y_i     (box_y_q),
    .box_z_i     (box_z_q),
    .disp_x_o    (disp_x),
    .disp_y_o    (disp_y),
    .disp_z_o    (disp_z),
    .dist_o      (pair_dist)
  );

  assign m_axis_tdata = {3'b000, pair_dist, disp_z, disp_y, disp_x, index_j, index_i};

endmodule

@@ verif/tb_min_image_pair_distances.sv @@
// ----------------------------------------------------------------------------
// tb_min_image_pair_distances
// self-checking testbench for the minimum-image pair distance block
// ----------------------------------------------------------------------------
// Atoms are sent as structures with random positions over several wrap and
// box settings. A scoreboard predicts every pair result (wrapped displacement,
// truncated root distance, last-pair mark) and the overflow result of a full
// store, and compares each result field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_min_image_pair_distances;
  timeunit 1ns;
  timeprecision 1ps;
  import mipd_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned IdleLimit  = 3000;

  typedef struct packed {
    logic [IdxW-1:0]  idx_i;
    logic [IdxW-1:0]  idx_j;
    logic [DispW-1:0] dx;
    logic [DispW-1:0] dy;
    logic [DispW-1:0] dz;
    logic [DistW-1:0] pdist;
    logic             ovf;
    logic             last;
  } pair_res_t;

  class pair_scoreboard;
    logic [PosW-1:0] atom_x[StoreDepth];
    logic [PosW-1:0] atom_y[StoreDepth];
    logic [PosW-1:0] atom_z[StoreDepth];
    int unsigned     n_atoms;
    bit              wrap_on;
    longint          box[3];
    pair_res_t       pending_q[$];
    int unsigned     n_bad;

    function new();
      n_atoms = 0;
      wrap_on = 0;
      box = '{0, 0, 0};
      n_bad = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] val);
      case (addr)
        RegPbcEnable: wrap_on = val[0];
        RegBoxX: box[0] = longint'(val);
        RegBoxY: box[1] = longint'(val);
        RegBoxZ: box[2] = longint'(val);
        default: ;
      endcase
    endfunction

    function longint min_image(longint d, longint l);
      if (!wrap_on) return d;
      if (2 * d > l) return d - l;
      if (2 * d < -l) return d + l;
      return d;
    endfunction

    function logic [DistW-1:0] root_dist(longint dx, longint dy, longint dz);
      logic [127:0] ax, ay, az, s, t;
      logic [DistW-1:0] r;
      ax = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay = (dy < 0) ? 128'(-dy) : 128'(dy);
      az = (dz < 0) ? 128'(-dz) : 128'(dz);
      s = ax * ax + ay * ay + az * az;
      r = '0;
      for (int b = DistW - 1; b >= 0; b--) begin
        t = 128'(r | (DistW'(1) << b));
        if (t * t <= s) r = t[DistW-1:0];
      end
      return r;
    endfunction

    function void note_atom(bit start, logic [PosW-1:0] px, logic [PosW-1:0] py,
                            logic [PosW-1:0] pz);
      pair_res_t e;
      longint d[3];
      if (start) n_atoms = 0;
      if (n_atoms >= StoreDepth) begin
        e = '{default: '0};
        e.ovf = 1'b1;
        e.last = 1'b1;
        pending_q.push_back(e);
        return;
      end
      for (int j = 0; j < n_atoms; j++) begin
        d[0] = min_image(longint'($signed(px)) - longint'($signed(atom_x[j])), box[0]);
        d[1] = min_image(longint'($signed(py)) - longint'($signed(atom_y[j])), box[1]);
        d[2] = min_image(longint'($signed(pz)) - longint'($signed(atom_z[j])), box[2]);
        e.idx_i = IdxW'(n_atoms);
        e.idx_j = IdxW'(j);
        e.dx = d[0][DispW-1:0];
        e.dy = d[1][DispW-1:0];
        e.dz = d[2][DispW-1:0];
        e.pdist = root_dist(d[0], d[1], d[2]);
        e.ovf = 1'b0;
        e.last = (j + 1 == n_atoms);
        pending_q.push_back(e);
      end
      atom_x[n_atoms] = px;
      atom_y[n_atoms] = py;
      atom_z[n_atoms] = pz;
      n_atoms++;
    endfunction

    function void check_pair(logic [OutDataW-1:0] data, logic user, logic last);
      pair_res_t a, e;
      a.idx_i = data[5:0];
      a.idx_j = data[11:6];
      a.dx = data[45:12];
      a.dy = data[79:46];
      a.dz = data[113:80];
      a.pdist = data[148:114];
      a.ovf = user;
      a.last = last;
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected item: i=%0d j=%0d", a.idx_i, a.idx_j);
        return;
      end
      e = pending_q.pop_front();
      if (a != e || data[OutDataW-1:149] != '0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch exp i=%0d j=%0d dx=%h dy=%h dz=%h d=%h o=%b l=%b\n"
                   , e.idx_i, e.idx_j, e.dx, e.dy, e.dz, e.pdist, e.ovf, e.last,
                   "         got i=%0d j=%0d dx=%h dy=%h dz=%h d=%h o=%b l=%b",
                   a.idx_i, a.idx_j, a.dx, a.dy, a.dz, a.pdist, a.ovf, a.last);
      end
    endfunction
  endclass

  logic                   clk_i, rst_ni;
  logic                   s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [InDataW-1:0]     s_axis_tdata;
  logic                   m_axis_tvalid, m_axis_tready, m_axis_tuser, m_axis_tlast;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   cfg_we_i;
  logic [CfgAddrW-1:0]    cfg_addr_i;
  logic [CfgDataW-1:0]    cfg_wdata_i;

  pair_scoreboard sb;
  bit             stalls_on;
  int unsigned    idle_cycles;

  min_image_pair_distances uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_atom(bit start, logic [PosW-1:0] px, logic [PosW-1:0] py,
                           logic [PosW-1:0] pz);
    int gap;
    gap = stalls_on ? $urandom_range(0, 18) : 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = start;
    s_axis_tdata = {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_atom(start, px, py, pz);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = val;
    sb.set_reg(addr, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_boxes(bit wrap, logic [BoxW-1:0] bx, logic [BoxW-1:0] by,
                           logic [BoxW-1:0] bz);
    write_reg(RegPbcEnable, CfgDataW'(wrap));
    write_reg(RegBoxX, bx);
    write_reg(RegBoxY, by);
    write_reg(RegBoxZ, bz);
  endtask

  function automatic logic [PosW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return PosW'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return PosW'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  task automatic random_structures(int n_items);
    int sent, size;
    sent = 0;
    while (sent < n_items) begin
      size = $urandom_range(1, 8);
      for (int k = 0; k < size && sent < n_items; k++) begin
        bit st;
        st = (k == 0) ? ($urandom_range(0, 9) != 0 || sb.n_atoms > 16)
                      : ($urandom_range(0, 24) == 0);
        send_atom(st, rand_coord(), rand_coord(), rand_coord());
        sent++;
      end
      if ($urandom_range(0, 5) == 0) stalls_on = ~stalls_on;
    end
  endtask

  // result side
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      @(negedge clk_i);
      gap = stalls_on ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_pair(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no item moved for %0d cycles", IdleLimit);
        $display("** min_image_pair_distances: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    stalls_on = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = RegPbcEnable;
    cfg_wdata_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed extremes, no wrapping
    set_boxes(1'b0, '0, '0, '0);
    send_atom(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_atom(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_atom(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_atom(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_atom(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_atom(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_atom(1'b1, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F);
    drain();

    // zero box with wrapping on
    set_boxes(1'b1, '0, '0, '0);
    send_atom(1'b1, 32'h0005_0000, 32'hFFFB_0000, 32'h0000_0000);
    send_atom(1'b0, 32'hFFFB_0000, 32'h0005_0000, 32'h0000_0001);
    drain();

    // largest box, exact half-box boundaries
    set_boxes(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_atom(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_atom(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_FFFF);
    send_atom(1'b0, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000);
    drain();

    // small box: fill the store, then two dropped atoms
    set_boxes(1'b1, 31'h000A_0000, 31'h0010_0000, 31'h0000_0001);
    stalls_on = 1'b0;
    for (int k = 0; k < StoreDepth + 2; k++)
      send_atom(k == 0, rand_coord(), rand_coord(), rand_coord());
    stalls_on = 1'b1;
    random_structures(80);
    drain();

    set_boxes(1'b0, 31'h7FFF_FFFF, 31'h0000_0000, 31'h1234_5678);
    random_structures(80);
    drain();

    set_boxes(1'b1, 31'h7FFF_FFFF, 31'h4000_0000, 31'h0100_0000);
    random_structures(80);
    drain();

    set_boxes(1'b1, BoxW'($urandom()), BoxW'($urandom_range(1, 32'h0200_0000)),
              BoxW'($urandom()));
    random_structures(80);
    drain();

    set_boxes(1'b1, 31'h0040_0000, 31'h0000_0000, 31'h0004_0000);
    random_structures(80);
    drain();

    if (sb.n_bad == 0 && sb.pending_q.size() == 0)
      $display("** min_image_pair_distances: PASSED **");
    else
      $display("** min_image_pair_distances: FAILED **");
    $finish;
  end

endmodule
